>>> src/bed_pkg.sv
package bed_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned CntW    = 2;

  localparam logic [ByteW-1:0] ChrBslash = 8'h5c;
  localparam logic [ByteW-1:0] ChrN      = 8'h6e;
  localparam logic [ByteW-1:0] ChrR      = 8'h72;
  localparam logic [ByteW-1:0] ChrT      = 8'h74;
  localparam logic [ByteW-1:0] ChrV      = 8'h76;
  localparam logic [ByteW-1:0] ChrX      = 8'h78;
  localparam logic [ByteW-1:0] ChrLf     = 8'h0a;
  localparam logic [ByteW-1:0] ChrCr     = 8'h0d;
  localparam logic [ByteW-1:0] ChrTab    = 8'h09;
  localparam logic [ByteW-1:0] ChrVt     = 8'h0b;

  localparam logic OpText = 1'b0;
  localparam logic OpEnd  = 1'b1;

  typedef enum logic [3:0] {
    PhPlain = 4'b0001,
    PhSlash = 4'b0010,
    PhX     = 4'b0100,
    PhX1    = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             byte_valid;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             is_hex;
    logic [DigitW-1:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = DigitW'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = DigitW'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = DigitW'(c - 8'h37);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> src/bed_decode.sv
module bed_decode import bed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              escape_enable_i,
  input  logic              op_i,
  input  logic [ByteW-1:0]  in_byte_i,
  output logic [CntW-1:0]   res_cnt_o,
  output res_t              res_o [MaxRes]
);

  phase_e            phase_q, phase_d;
  logic [DigitW-1:0] digit_q, digit_d;
  hex_t              hex;
  logic [CntW-1:0]   k;

  always_comb begin
    hex      = hex_decode(in_byte_i);
    phase_d  = phase_q;
    digit_d  = digit_q;
    k        = '0;
    for (int i = 0; i < MaxRes; i++) begin
      res_o[i] = '{data: '0, byte_valid: 1'b0, last: 1'b0};
    end

    if (op_i == OpEnd) begin
      unique case (phase_q)
        PhSlash: begin
          res_o[0] = '{data: ChrBslash, byte_valid: 1'b1, last: 1'b1};
          k = 2'd1;
        end
        PhX: begin
          res_o[0] = '{data: ChrBslash, byte_valid: 1'b1, last: 1'b0};
          res_o[1] = '{data: ChrX, byte_valid: 1'b1, last: 1'b1};
          k = 2'd2;
        end
        PhX1: begin
          res_o[0] = '{data: {{(ByteW-DigitW){1'b0}}, digit_q}, byte_valid: 1'b1, last: 1'b1};
          k = 2'd1;
        end
        default: begin
          res_o[0] = '{data: '0, byte_valid: 1'b0, last: 1'b1};
          k = 2'd1;
        end
      endcase
      phase_d = PhPlain;
      digit_d = '0;
    end else begin
      unique case (phase_q)
        PhSlash: begin
          phase_d = PhPlain;
          k = 2'd1;
          unique case (in_byte_i)
            ChrN:      res_o[0] = '{data: ChrLf, byte_valid: 1'b1, last: 1'b0};
            ChrR:      res_o[0] = '{data: ChrCr, byte_valid: 1'b1, last: 1'b0};
            ChrT:      res_o[0] = '{data: ChrTab, byte_valid: 1'b1, last: 1'b0};
            ChrV:      res_o[0] = '{data: ChrVt, byte_valid: 1'b1, last: 1'b0};
            ChrBslash: res_o[0] = '{data: ChrBslash, byte_valid: 1'b1, last: 1'b0};
            ChrX: begin
              phase_d = PhX;
              k = 2'd0;
            end
            default: begin
              res_o[0] = '{data: ChrBslash, byte_valid: 1'b1, last: 1'b0};
              res_o[1] = '{data: in_byte_i, byte_valid: 1'b1, last: 1'b0};
              k = 2'd2;
            end
          endcase
        end
        PhX: begin
          if (hex.is_hex) begin
            digit_d = hex.value;
            phase_d = PhX1;
          end else begin
            res_o[0] = '{data: ChrBslash, byte_valid: 1'b1, last: 1'b0};
            res_o[1] = '{data: ChrX, byte_valid: 1'b1, last: 1'b0};
            if (escape_enable_i && in_byte_i == ChrBslash) begin
              phase_d = PhSlash;
              k = 2'd2;
            end else begin
              phase_d = PhPlain;
              res_o[2] = '{data: in_byte_i, byte_valid: 1'b1, last: 1'b0};
              k = 2'd3;
            end
          end
        end
        PhX1: begin
          if (hex.is_hex) begin
            res_o[0] = '{data: {digit_q, hex.value}, byte_valid: 1'b1, last: 1'b0};
            k = 2'd1;
            phase_d = PhPlain;
          end else begin
            res_o[0] = '{data: {{(ByteW-DigitW){1'b0}}, digit_q}, byte_valid: 1'b1, last: 1'b0};
            if (escape_enable_i && in_byte_i == ChrBslash) begin
              phase_d = PhSlash;
              k = 2'd1;
            end else begin
              phase_d = PhPlain;
              res_o[1] = '{data: in_byte_i, byte_valid: 1'b1, last: 1'b0};
              k = 2'd2;
            end
          end
          digit_d = '0;
        end
        default: begin
          if (escape_enable_i && in_byte_i == ChrBslash) begin
            phase_d = PhSlash;
          end else begin
            phase_d = PhPlain;
            res_o[0] = '{data: in_byte_i, byte_valid: 1'b1, last: 1'b0};
            k = 2'd1;
          end
        end
      endcase
    end
    res_cnt_o = k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPlain;
      digit_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      digit_q <= digit_d;
    end
  end

endmodule

>>> src/bed_out_buf.sv
module bed_out_buf import bed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [CntW-1:0]  res_cnt_i,
  input  res_t             res_i [MaxRes],
  output logic             load_ok_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output res_t             m_res_o
);

  logic [CntW-1:0] rem_q, rem_d;
  res_t            ent_q [MaxRes];
  logic            pop;

  assign m_valid_o = (rem_q != '0);
  assign pop       = m_valid_o && m_ready_i;
  assign load_ok_o = (rem_q == '0) || (rem_q == CntW'(1) && pop);
  assign m_res_o   = ent_q[0];

  always_comb begin
    rem_d = rem_q;
    if (load_i) begin
      rem_d = res_cnt_i;
    end else if (pop) begin
      rem_d = rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= res_i;
    end else if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

endmodule

>>> src/backslash_escape_decoder_unit.sv
// path: a byte passes through the input register and then the result buffer to the output
// throughput: one input transaction per cycle while the result buffer can take it; an item
//   that yields two or three bytes holds the input while the result buffer drains
// reset: asynchronous active low; escapes disabled, plain-text phase, buffers empty
module backslash_escape_decoder_unit import bed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i,      // escape_enable
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [ByteW-1:0] s_axis_tdata_i,  // in_byte
  input  logic             s_axis_tuser_i,  // op
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [ByteW-1:0] m_axis_tdata_o,  // out_byte
  output logic             m_axis_tuser_o,  // byte_valid
  output logic             m_axis_tlast_o   // end_of_output
);

  logic             enable_q;
  logic             in_vld_q;
  logic             in_op_q;
  logic [ByteW-1:0] in_byte_q;
  logic             load_ok;
  logic             advance;
  logic [CntW-1:0]  res_cnt;
  res_t             res [MaxRes];
  res_t             m_res;

  assign cfg_ready_o     = 1'b1;
  assign advance         = in_vld_q && load_ok;
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      in_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        enable_q <= cfg_data_i;
      end
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_op_q   <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  bed_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .escape_enable_i (enable_q),
    .op_i            (in_op_q),
    .in_byte_i       (in_byte_q),
    .res_cnt_o       (res_cnt),
    .res_o           (res)
  );

  bed_out_buf u_out_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .res_cnt_i (res_cnt),
    .res_i     (res),
    .load_ok_o (load_ok),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata_o = m_res.data;
  assign m_axis_tuser_o = m_res.byte_valid;
  assign m_axis_tlast_o = m_res.last;

endmodule
